FILE: rtl/core/bilinear_image_resize_assert.svh
`ifndef BILINEAR_IMAGE_RESIZE_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_ASSERT_SVH

// same-cycle implication
`define BIR_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("bilinear_image_resize check failed");

// next-cycle implication
`define BIR_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("bilinear_image_resize check failed");

`endif

FILE: rtl/core/bir_pkg.sv
package bir_pkg;

    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH  = 256;
    localparam int CHANNELS   = 3;

    localparam int STORE_DEPTH = MAX_HEIGHT * MAX_WIDTH * CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int COL_W       = $clog2(MAX_WIDTH);

    localparam int ROW_IN_W = 8;
    localparam int COL_IN_W = 8;
    localparam int CH_W     = 2;
    localparam int VAL_W    = 8;
    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int SCALE_W  = 25;
    localparam int FRAC_W   = 16;
    localparam int SY_W     = ROW_IN_W + SCALE_W;
    localparam int SX_W     = COL_IN_W + SCALE_W;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int TAPS        = 4;
    localparam int TAP_W       = $clog2(TAPS);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [2:0] {
        REG_SRC_HEIGHT = 3'd0,
        REG_SRC_WIDTH  = 3'd1,
        REG_DST_HEIGHT = 3'd2,
        REG_DST_WIDTH  = 3'd3,
        REG_SCALE_Y    = 3'd4,
        REG_SCALE_X    = 3'd5
    } bir_reg_e_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_ERROR = 2'd2
    } bir_kind_t;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_MUL  = 2'd1,
        F_PUSH = 2'd2
    } bir_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_LAST = 2'd2,
        B_HZ   = 2'd3
    } bir_back_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  src_height;
        logic [SIZE_W-1:0]  src_width;
        logic [SIZE_W-1:0]  dst_height;
        logic [SIZE_W-1:0]  dst_width;
        logic [SCALE_W-1:0] scale_y;
        logic [SCALE_W-1:0] scale_x;
    } bir_cfg_t;

    typedef struct packed {
        bir_kind_t          kind;
        logic [ROW_W-1:0]   u0;
        logic [ROW_W-1:0]   u1;
        logic [COL_W-1:0]   v0;
        logic [COL_W-1:0]   v1;
        logic [CH_W-1:0]    ch;
        logic [VAL_W-1:0]   value;
        logic [FRAC_W-1:0]  fy;
        logic [FRAC_W-1:0]  fx;
    } bir_req_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input int maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            r = SIZE_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] u,
                                                     input logic [COL_W-1:0] v,
                                                     input logic [CH_W-1:0]  ch);
        return ADDR_W'((32'(u) * MAX_WIDTH + 32'(v)) * CHANNELS + 32'(ch));
    endfunction

endpackage

FILE: rtl/core/bir_ram.sv
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bir_queue.sv
module bir_queue
    import bir_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  bir_req_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output bir_req_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bir_req_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/bir_front.sv
module bir_front
    import bir_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  bir_cfg_t            cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic [ROW_IN_W-1:0] in_row,
    input  logic [COL_IN_W-1:0] in_col,
    input  logic [CH_W-1:0]     in_ch,
    input  logic [VAL_W-1:0]    in_value,
    output logic                push_valid,
    input  logic                push_ready,
    output bir_req_t            push_data
);

    bir_front_state_t state_reg, state_next;

    logic                cmd_reg;
    logic [ROW_IN_W-1:0] row_reg;
    logic [COL_IN_W-1:0] col_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [VAL_W-1:0]    val_reg;
    bir_kind_t           kind_reg, kind_next;
    logic [SY_W-1:0]     sy_reg;
    logic [SX_W-1:0]     sx_reg;

    logic [SIZE_W-1:0]   sh, sw, dh, dw;
    logic                ch_bad;
    logic [SY_W-FRAC_W-1:0] iy;
    logic [SX_W-FRAC_W-1:0] ix;
    logic [ROW_W-1:0]    u0, u1;
    logic [COL_W-1:0]    v0, v1;

    assign sh = eff_size(cfg.src_height, MAX_HEIGHT);
    assign sw = eff_size(cfg.src_width, MAX_WIDTH);
    assign dh = eff_size(cfg.dst_height, MAX_HEIGHT);
    assign dw = eff_size(cfg.dst_width, MAX_WIDTH);
    assign ch_bad = (32'(ch_reg) >= CHANNELS);

    always_comb begin
        if (cmd_reg) begin
            if ((32'(row_reg) >= 32'(dh)) || (32'(col_reg) >= 32'(dw)) || ch_bad) begin
                kind_next = KIND_ERROR;
            end else begin
                kind_next = KIND_READ;
            end
        end else begin
            if ((32'(row_reg) >= 32'(sh)) || (32'(col_reg) >= 32'(sw)) || ch_bad) begin
                kind_next = KIND_ERROR;
            end else begin
                kind_next = KIND_WRITE;
            end
        end
    end

    // source position, clamped to the last row and column
    assign iy = sy_reg[SY_W-1:FRAC_W];
    assign ix = sx_reg[SX_W-1:FRAC_W];

    always_comb begin
        if (kind_reg == KIND_READ) begin
            u0 = (32'(iy) >= 32'(sh)) ? ROW_W'(sh - 1'b1) : ROW_W'(iy);
            v0 = (32'(ix) >= 32'(sw)) ? COL_W'(sw - 1'b1) : COL_W'(ix);
        end else begin
            u0 = ROW_W'(row_reg);
            v0 = COL_W'(col_reg);
        end
        u1 = (32'(u0) + 1 >= 32'(sh)) ? ROW_W'(sh - 1'b1) : ROW_W'(32'(u0) + 1);
        v1 = (32'(v0) + 1 >= 32'(sw)) ? COL_W'(sw - 1'b1) : COL_W'(32'(v0) + 1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    state_next = F_MUL;
                end
            end
            F_MUL:  state_next = F_PUSH;
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        in_ready         = 1'b0;
        push_valid       = 1'b0;
        push_data.kind   = kind_reg;
        push_data.u0     = u0;
        push_data.u1     = u1;
        push_data.v0     = v0;
        push_data.v1     = v1;
        push_data.ch     = ch_reg;
        push_data.value  = val_reg;
        push_data.fy     = sy_reg[FRAC_W-1:0];
        push_data.fx     = sx_reg[FRAC_W-1:0];
        case (state_reg)
            F_IDLE:  in_ready   = 1'b1;
            F_PUSH:  push_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            cmd_reg <= in_cmd;
            row_reg <= in_row;
            col_reg <= in_col;
            ch_reg  <= in_ch;
            val_reg <= in_value;
        end
        if (state_reg == F_MUL) begin
            kind_reg <= kind_next;
            sy_reg   <= SY_W'(row_reg) * SY_W'(cfg.scale_y);
            sx_reg   <= SX_W'(col_reg) * SX_W'(cfg.scale_x);
        end
    end

endmodule

FILE: rtl/core/bir_back.sv
module bir_back
    import bir_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  bir_req_t         q_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel,
    output logic             out_error
);

    localparam int VW = PIX_W + FRAC_W;
    localparam int YW = VW + FRAC_W + 2;

    bir_back_state_t state_reg, state_next;

    bir_req_t          cur_reg;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [PIX_W-1:0]  p00_reg, p10_reg, p01_reg;
    logic [VW-1:0]     a_reg, b_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_pixel_reg;
    logic              m_error_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr, tap_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic              out_free, out_load, load_error;
    logic [PIX_W-1:0]  load_pixel, hz_pixel;

    logic signed [VW:0]   hz_diff;
    logic signed [YW-1:0] hz_prod, hz_sum;
    logic [YW-2*FRAC_W-1:0] hz_int;

    function automatic logic [VW-1:0] vlerp(input logic [PIX_W-1:0]  p0,
                                            input logic [PIX_W-1:0]  p1,
                                            input logic [FRAC_W-1:0] f);
        logic signed [PIX_W:0]      d;
        logic signed [VW+1:0]       prod;
        logic signed [VW+1:0]       sum;
        d    = $signed({1'b0, p1}) - $signed({1'b0, p0});
        prod = d * $signed({1'b0, f});
        sum  = $signed({2'b00, p0, FRAC_W'(0)}) + prod;
        return sum[VW-1:0];
    endfunction

    bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_data.value),
        .rdata (ram_rdata)
    );

    // neighbor order: top-left, bottom-left, top-right, bottom-right
    always_comb begin
        case (tap_reg)
            2'd0:    tap_addr = store_addr(cur_reg.u0, cur_reg.v0, cur_reg.ch);
            2'd1:    tap_addr = store_addr(cur_reg.u1, cur_reg.v0, cur_reg.ch);
            2'd2:    tap_addr = store_addr(cur_reg.u0, cur_reg.v1, cur_reg.ch);
            default: tap_addr = store_addr(cur_reg.u1, cur_reg.v1, cur_reg.ch);
        endcase
    end

    // horizontal blend of the two column sums, Q.32
    assign hz_diff = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
    assign hz_prod = hz_diff * $signed({1'b0, cur_reg.fx});
    assign hz_sum  = $signed({2'b00, a_reg, FRAC_W'(0)}) + hz_prod;
    assign hz_int  = hz_sum[YW-1:2*FRAC_W];
    assign hz_pixel = (hz_int > {{(YW-2*FRAC_W-PIX_W){1'b0}}, PIX_MAX}) ? PIX_MAX
                                                                     : hz_int[PIX_W-1:0];

    assign out_free = !m_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        case (state_reg)
            B_IDLE: begin
                tap_next = '0;
                if (q_valid && (q_data.kind == KIND_READ)) begin
                    state_next = B_READ;
                end
            end
            B_READ: begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == TAP_W'(TAPS - 1)) begin
                    state_next = B_LAST;
                end
            end
            B_LAST: state_next = B_HZ;
            B_HZ: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = tap_addr;
        out_load   = 1'b0;
        load_pixel = '0;
        load_error = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_data.kind == KIND_READ) begin
                        q_pop = 1'b1;
                    end else if (out_free) begin
                        q_pop      = 1'b1;
                        out_load   = 1'b1;
                        load_error = (q_data.kind == KIND_ERROR);
                        ram_we     = (q_data.kind == KIND_WRITE);
                        ram_addr   = store_addr(q_data.u0, q_data.v0, q_data.ch);
                    end
                end
            end
            B_HZ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    load_pixel = hz_pixel;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            tap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == B_IDLE) && q_valid && (q_data.kind == KIND_READ)) begin
            cur_reg <= q_data;
        end
        if (state_reg == B_READ) begin
            case (tap_reg)
                2'd1: p00_reg <= ram_rdata;
                2'd2: p10_reg <= ram_rdata;
                2'd3: begin
                    p01_reg <= ram_rdata;
                    a_reg   <= vlerp(p00_reg, p10_reg, cur_reg.fy);
                end
                default: ;
            endcase
        end
        if (state_reg == B_LAST) begin
            b_reg <= vlerp(p01_reg, ram_rdata, cur_reg.fy);
        end
        if (out_load) begin
            m_pixel_reg <= load_pixel;
            m_error_reg <= load_error;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_pixel = m_pixel_reg;
    assign out_error = m_error_reg;

endmodule

FILE: rtl/core/bilinear_image_resize.sv
// Path: a write or rejected request goes through the front's F_MUL and F_PUSH states
// and the queue to the output register; a pixel read also passes B_READ, B_LAST and B_HZ.
// Flow: the front takes a new request only after it has pushed the last one; a read
// holds the back end through four single-port frame store fetches and the blend.
// Reset: synchronous, active low; registers return to defaults, queue and output
// empty. Frame store contents are undefined until written.
module bilinear_image_resize
    import bir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // row, col, channel, value, zero pad
    input  logic [0:0]            s_tuser,  // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // pixel
    output logic [0:0]            m_tuser,  // error
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    bir_cfg_t   cfg_reg;
    bir_reg_e_t reg_sel;
    logic       cfg_write;

    logic       push_valid, push_ready;
    bir_req_t   push_data;
    logic       q_valid, q_pop;
    bir_req_t   q_data;

    assign pready    = 1'b1;
    assign reg_sel   = bir_reg_e_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_height <= SIZE_W'(256);
            cfg_reg.src_width  <= SIZE_W'(256);
            cfg_reg.dst_height <= SIZE_W'(256);
            cfg_reg.dst_width  <= SIZE_W'(256);
            cfg_reg.scale_y    <= SCALE_W'(65536);
            cfg_reg.scale_x    <= SCALE_W'(65536);
        end else if (cfg_write) begin
            case (reg_sel)
                REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[SIZE_W-1:0];
                REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[SIZE_W-1:0];
                REG_DST_HEIGHT: cfg_reg.dst_height <= pwdata[SIZE_W-1:0];
                REG_DST_WIDTH:  cfg_reg.dst_width  <= pwdata[SIZE_W-1:0];
                REG_SCALE_Y:    cfg_reg.scale_y    <= pwdata[SCALE_W-1:0];
                REG_SCALE_X:    cfg_reg.scale_x    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SRC_HEIGHT: prdata = CFG_DATA_W'(cfg_reg.src_height);
            REG_SRC_WIDTH:  prdata = CFG_DATA_W'(cfg_reg.src_width);
            REG_DST_HEIGHT: prdata = CFG_DATA_W'(cfg_reg.dst_height);
            REG_DST_WIDTH:  prdata = CFG_DATA_W'(cfg_reg.dst_width);
            REG_SCALE_Y:    prdata = CFG_DATA_W'(cfg_reg.scale_y);
            REG_SCALE_X:    prdata = CFG_DATA_W'(cfg_reg.scale_x);
            default:        prdata = '0;
        endcase
    end

    bir_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_row     (s_tdata[ROW_IN_W-1:0]),
        .in_col     (s_tdata[ROW_IN_W+COL_IN_W-1:ROW_IN_W]),
        .in_ch      (s_tdata[ROW_IN_W+COL_IN_W+CH_W-1:ROW_IN_W+COL_IN_W]),
        .in_value   (s_tdata[ROW_IN_W+COL_IN_W+CH_W+VAL_W-1:ROW_IN_W+COL_IN_W+CH_W]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bir_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    bir_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_error (m_tuser[0])
    );

endmodule

FILE: rtl/core/bir_checker.sv
`include "bilinear_image_resize_assert.svh"

module bir_checker
    import bir_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    `BIR_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `BIR_ASSERT_IMPL(a_err_zero, aclk, !aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `BIR_ASSERT_NEXT(a_in_gap, aclk, !aresetn, s_tvalid && s_tready, !s_tready)
    `BIR_ASSERT_NEXT(a_rst_empty, aclk, 1'b0, !aresetn, !m_tvalid)

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
